>>> rtl/core/pfsa_pkg.sv
// Shared constants and request/status codes of the page frame stack allocator.
package pfsa_pkg;

	localparam int STACK_DEPTH = 4096;
	localparam int PAGE_BYTES  = 4096;

	localparam int ADDR_W = $clog2(STACK_DEPTH);
	localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
	localparam int FRAME_W = 32;

	localparam logic [1:0] REQ_ADD   = 2'd0;
	localparam logic [1:0] REQ_SEAL  = 2'd1;
	localparam logic [1:0] REQ_ALLOC = 2'd2;
	localparam logic [1:0] REQ_FREE  = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

endpackage

>>> rtl/core/page_frame_stack_allocator.sv
// Top level of the page frame stack allocator: sequencer, stack RAM and result register.
//
// A stack of free physical page frames. Requests enter on in_valid/in_ready:
// add region (push every page step of a usable region above the first-free
// address), seal (reverse the stack), allocate (pop) and free (push). Each
// request yields exactly one result beat on out_valid/out_ready carrying
// frame_addr, status and frames_free.
// cfg_valid/cfg_ready/cfg_data writes min_free_addr, which reloads the
// first-free address; cfg_ready is always high.
// in_ready is high only while the sequencer is idle. Free and empty
// allocate go straight to the done state, allocate reads the top in the
// pop state, seal runs read-low, read-high, write-low, write-high per
// swapped pair, and add region pushes one frame per add step. The stack
// RAM has one read and one write port; the region loader uses one adder
// and comparator per pushed frame. The result register, loaded from the
// done state, holds the finished beat; if the receiver stalls, the next
// request is still worked on and waits only at its end until it is taken.
// Reset clears the stack count, the first-free address and out_valid; the
// stack RAM itself needs no clearing since only entries below the count
// are read.
module page_frame_stack_allocator
	import pfsa_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         req_type,
	input  logic [31:0]        region_base,
	input  logic [63:0]        region_length,
	input  logic               region_usable,
	input  logic [31:0]        freed_frame,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [31:0]        frame_addr,
	output logic [1:0]         status,
	output logic [CNT_W-1:0]   frames_free,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [31:0]        cfg_data
);

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_ADD  = 8'b0000_0010,
		ST_POP  = 8'b0000_0100,
		ST_RLO  = 8'b0000_1000,
		ST_RHI  = 8'b0001_0000,
		ST_WLO  = 8'b0010_0000,
		ST_WHI  = 8'b0100_0000,
		ST_DONE = 8'b1000_0000
	} state_t;

	state_t state_q;

	logic [CNT_W-1:0]   count_q;
	logic [31:0]        next_free_q;
	logic               out_valid_q;

	logic [32:0]        f_q;
	logic [31:0]        end_q;
	logic [CNT_W-1:0]   lo_q;
	logic [CNT_W-1:0]   hi_q;
	logic [FRAME_W-1:0] tmp_q;
	logic [31:0]        res_frame_q;
	logic [1:0]         res_status_q;
	logic [31:0]        frame_addr_q;
	logic [1:0]         status_q;
	logic [CNT_W-1:0]   frames_free_q;

	logic [31:0]        region_end;
	logic [31:0]        region_start;
	logic [CNT_W-1:0]   cnt_m1;
	logic [CNT_W-1:0]   hi_m1;
	logic               full;
	logic               in_range;
	logic               slot_free;

	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr;
	logic [FRAME_W-1:0] ram_wdata;
	logic [ADDR_W-1:0]  ram_raddr;
	logic [FRAME_W-1:0] ram_rdata;

	assign region_end   = region_base + region_length[31:0];
	assign region_start = (next_free_q < region_base) ? region_base : next_free_q;
	assign cnt_m1       = count_q - CNT_W'(1);
	assign hi_m1        = hi_q - CNT_W'(1);
	assign full         = (count_q == CNT_W'(STACK_DEPTH));
	assign in_range     = (f_q < {1'b0, end_q});
	assign slot_free    = !out_valid_q || out_ready;

	assign in_ready    = (state_q == ST_IDLE);
	assign cfg_ready   = 1'b1;
	assign out_valid   = out_valid_q;
	assign frame_addr  = frame_addr_q;
	assign status      = status_q;
	assign frames_free = frames_free_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = count_q[ADDR_W-1:0];
		ram_wdata = freed_frame;
		ram_raddr = cnt_m1[ADDR_W-1:0];
		case (state_q)
			ST_IDLE: begin
				if (in_valid && req_type == REQ_FREE && !full) begin
					ram_we = 1'b1;
				end
			end
			ST_ADD: begin
				ram_wdata = f_q[31:0];
				if (in_range && !full) begin
					ram_we = 1'b1;
				end
			end
			ST_RLO: ram_raddr = lo_q[ADDR_W-1:0];
			ST_RHI: ram_raddr = hi_m1[ADDR_W-1:0];
			ST_WLO: begin
				ram_we    = 1'b1;
				ram_waddr = lo_q[ADDR_W-1:0];
				ram_wdata = ram_rdata;
			end
			ST_WHI: begin
				ram_we    = 1'b1;
				ram_waddr = hi_m1[ADDR_W-1:0];
				ram_wdata = tmp_q;
			end
			default: ;
		endcase
	end

	pfsa_ram #(
		.WIDTH(FRAME_W),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			next_free_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				next_free_q <= cfg_data;
			end
			if (state_q == ST_DONE && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						case (req_type)
							REQ_ADD: begin
								if (region_usable && next_free_q < region_end) begin
									state_q <= ST_ADD;
								end else begin
									state_q <= ST_DONE;
								end
							end
							REQ_SEAL: begin
								state_q <= (count_q > CNT_W'(1)) ? ST_RLO : ST_DONE;
							end
							REQ_ALLOC: begin
								if (count_q != '0) begin
									count_q <= cnt_m1;
									state_q <= ST_POP;
								end else begin
									state_q <= ST_DONE;
								end
							end
							default: begin
								if (!full) begin
									count_q <= count_q + CNT_W'(1);
								end
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_ADD: begin
					if (in_range && !full) begin
						count_q <= count_q + CNT_W'(1);
					end else begin
						// region exhausted or stack full: drop the rest
						next_free_q <= end_q;
						state_q     <= ST_DONE;
					end
				end
				ST_POP: state_q <= ST_DONE;
				ST_RLO: state_q <= ST_RHI;
				ST_RHI: state_q <= ST_WLO;
				ST_WLO: state_q <= ST_WHI;
				ST_WHI: begin
					// continue while another pair remains after this swap
					state_q <= (lo_q + CNT_W'(3) < hi_q) ? ST_RLO : ST_DONE;
				end
				ST_DONE: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					res_frame_q  <= '0;
					res_status_q <= ST_OK;
					case (req_type)
						REQ_ADD: begin
							f_q   <= {1'b0, region_start};
							end_q <= region_end;
						end
						REQ_SEAL: begin
							lo_q <= '0;
							hi_q <= count_q;
						end
						REQ_ALLOC: begin
							if (count_q == '0) begin
								res_status_q <= ST_EMPTY;
							end
						end
						default: begin
							if (full) begin
								res_status_q <= ST_FULL;
							end
						end
					endcase
				end
			end
			ST_ADD: begin
				if (in_range) begin
					if (full) begin
						res_status_q <= ST_FULL;
					end else begin
						f_q <= f_q + 33'(PAGE_BYTES);
					end
				end
			end
			ST_POP: res_frame_q <= ram_rdata;
			ST_RHI: tmp_q <= ram_rdata;
			ST_WHI: begin
				lo_q <= lo_q + CNT_W'(1);
				hi_q <= hi_m1;
			end
			ST_DONE: begin
				if (slot_free) begin
					frame_addr_q  <= res_frame_q;
					status_q      <= res_status_q;
					frames_free_q <= count_q;
				end
			end
			default: ;
		endcase
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(STACK_DEPTH))
		else $error("stack count above depth");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (status_q != ST_EMPTY || frame_addr_q == '0))
		else $error("empty result carries a frame address");

	a_pop_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && req_type == REQ_ALLOC && count_q != '0)
		|=> (count_q == $past(count_q) - CNT_W'(1)))
		else $error("allocate did not pop one frame");

endmodule

>>> rtl/core/pfsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pfsa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> verif/pfsa_tb_pkg.sv
`timescale 1ns / 1ps
// Expected-result record and free frame ledger used by the allocator testbench.
package pfsa_tb_pkg;
	import pfsa_pkg::*;

	typedef struct {
		logic [31:0]      frame_addr;
		logic [1:0]       status;
		logic [CNT_W-1:0] frames_free;
	} frame_result_t;

	class free_frame_ledger;
		logic [31:0]   frames [STACK_DEPTH];
		int unsigned   depth;
		logic [31:0]   next_free;
		frame_result_t owed_results [$];
		int unsigned   mismatches;
		int unsigned   matched;
		int unsigned   region_frames;
		int unsigned   seals;
		int unsigned   empties;
		int unsigned   drops;

		function new();
			depth = 0;
			next_free = '0;
			mismatches = 0;
			matched = 0;
			region_frames = 0;
			seals = 0;
			empties = 0;
			drops = 0;
		endfunction

		// A floor write also reloads the first-free address.
		function void set_floor(logic [31:0] addr);
			next_free = addr;
		endfunction

		function bit push_frame(logic [31:0] addr);
			if (depth >= STACK_DEPTH)
				return 1'b0;
			frames[depth] = addr;
			depth++;
			return 1'b1;
		endfunction

		function void take_request(logic [1:0] req, logic [31:0] base, logic [63:0] len,
				logic usable, logic [31:0] freed);
			frame_result_t r;
			logic [31:0]   region_end;
			logic [31:0]   tmp;
			logic [32:0]   step;
			int unsigned   lo;
			int unsigned   hi;
			r.frame_addr = '0;
			r.status = ST_OK;
			case (req)
				REQ_ADD: begin
					if (usable) begin
						region_end = base + len[31:0];
						if (next_free < region_end) begin
							if (next_free < base)
								next_free = base;
							// steps follow the first-free address, not page alignment
							step = {1'b0, next_free};
							while (step < {1'b0, region_end}) begin
								if (!push_frame(step[31:0])) begin
									r.status = ST_FULL;
									break;
								end
								region_frames++;
								step = step + PAGE_BYTES;
							end
							next_free = region_end;
						end
					end
				end
				REQ_SEAL: begin
					seals++;
					lo = 0;
					hi = depth;
					while (lo + 1 < hi) begin
						tmp = frames[lo];
						frames[lo] = frames[hi - 1];
						frames[hi - 1] = tmp;
						lo++;
						hi--;
					end
				end
				REQ_ALLOC: begin
					if (depth == 0) begin
						r.status = ST_EMPTY;
						empties++;
					end else begin
						depth--;
						r.frame_addr = frames[depth];
					end
				end
				default: begin
					if (!push_frame(freed))
						r.status = ST_FULL;
				end
			endcase
			if (r.status == ST_FULL)
				drops++;
			r.frames_free = CNT_W'(depth);
			owed_results.push_back(r);
		endfunction

		function void match_result(logic [31:0] addr, logic [1:0] st, logic [CNT_W-1:0] cnt);
			frame_result_t e;
			if (owed_results.size() == 0) begin
				$display("%0t: result beat with nothing owed: frame_addr=%h status=%0d frames_free=%0d",
					$time, addr, st, cnt);
				mismatches++;
				return;
			end
			e = owed_results.pop_front();
			matched++;
			if (addr !== e.frame_addr) begin
				$display("%0t: frame_addr expected %h actual %h", $time, e.frame_addr, addr);
				mismatches++;
			end
			if (st !== e.status) begin
				$display("%0t: status expected %0d actual %0d", $time, e.status, st);
				mismatches++;
			end
			if (cnt !== e.frames_free) begin
				$display("%0t: frames_free expected %0d actual %0d", $time, e.frames_free, cnt);
				mismatches++;
			end
		endfunction
	endclass

endpackage

>>> verif/page_frame_stack_allocator_tb.sv
`timescale 1ns / 1ps
// Top-level testbench of the page frame stack allocator: stimulus, pacing and result checks.
module page_frame_stack_allocator_tb;
	import pfsa_pkg::*;
	import pfsa_tb_pkg::*;

	// Slowest item is a seal of a full stack plus stalls; the limit takes it several times over.
	localparam int unsigned LIMIT_CYCLES = 40_000_000;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [1:0]       req_type = REQ_ALLOC;
	logic [31:0]      region_base = '0;
	logic [63:0]      region_length = '0;
	logic             region_usable = 1'b0;
	logic [31:0]      freed_frame = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [31:0]      frame_addr;
	logic [1:0]       status;
	logic [CNT_W-1:0] frames_free;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [31:0]      cfg_data = '0;

	free_frame_ledger ledger;
	int unsigned      sent = 0;
	int unsigned      floor_writes = 0;
	int unsigned      rx_hold = 0;
	bit               rx_steady = 1'b0;

	always #2 clk = ~clk;

	page_frame_stack_allocator uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.req_type      (req_type),
		.region_base   (region_base),
		.region_length (region_length),
		.region_usable (region_usable),
		.freed_frame   (freed_frame),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.frame_addr    (frame_addr),
		.status        (status),
		.frames_free   (frames_free),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	// Receiver: mostly ready, short stalls, an occasional long one, steady stretches.
	always @(posedge clk) begin
		if (rx_hold != 0) begin
			rx_hold <= rx_hold - 1;
			out_ready <= 1'b0;
		end else if (rx_steady || $urandom_range(0, 99) < 70) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= 1'b0;
			rx_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
		end
		if ($urandom_range(0, 999) == 0)
			rx_steady <= !rx_steady;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			ledger.match_result(frame_addr, status, frames_free);
	end

	task automatic send_request(input logic [1:0] req, input logic [31:0] base,
			input logic [63:0] len, input logic usable, input logic [31:0] freed);
		in_valid <= 1'b1;
		req_type <= req;
		region_base <= base;
		region_length <= len;
		region_usable <= usable;
		freed_frame <= freed;
		do @(posedge clk); while (!in_ready);
		ledger.take_request(req, base, len, usable, freed);
		sent++;
	endtask

	task automatic pause(input int unsigned n);
		if (n != 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Hold off the sender until every owed result beat has been taken.
	task automatic drain();
		in_valid <= 1'b0;
		while (ledger.owed_results.size() != 0) @(posedge clk);
	endtask

	task automatic write_min_free(input logic [31:0] addr);
		drain();
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= addr;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		ledger.set_floor(addr);
		floor_writes++;
	endtask

	// Keep the stack shallow so seals stay cheap; regions mostly sit near the first-free address.
	task automatic random_request();
		logic [1:0]  req;
		logic [31:0] base;
		logic [31:0] lo;
		logic        usable;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (ledger.depth > 300)
			req = (pick < 80) ? REQ_ALLOC : (pick < 88) ? REQ_ADD : (pick < 98) ? REQ_FREE : REQ_SEAL;
		else if (ledger.depth > 80)
			req = (pick < 30) ? REQ_ADD : (pick < 33) ? REQ_SEAL : (pick < 70) ? REQ_ALLOC : REQ_FREE;
		else
			req = (pick < 35) ? REQ_ADD : (pick < 43) ? REQ_SEAL : (pick < 70) ? REQ_ALLOC : REQ_FREE;
		usable = ($urandom_range(0, 9) != 0);
		base = $urandom();
		lo = $urandom_range(0, 10 * PAGE_BYTES);
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: begin
				if ($urandom_range(0, 3) == 0)
					base = ledger.next_free - $urandom_range(0, 4 * PAGE_BYTES);
				else
					base = ledger.next_free + $urandom_range(0, 4 * PAGE_BYTES);
			end
			8: begin
				// base plus length carries out: the end wraps below the base
				base = base | 32'h8000_0000;
				lo = $urandom() | 32'h8000_0000;
			end
			9: begin
				lo = $urandom();
				usable = 1'b0;
			end
			default: begin
			end
		endcase
		send_request(req, base, {$urandom(), lo}, usable, $urandom());
	endtask

	initial begin
		for (int unsigned c = 0; c < LIMIT_CYCLES; c++) @(posedge clk);
		$display("page_frame_stack_allocator regression: fail");
		$finish;
	end

	initial begin
		logic [31:0] floors [5];
		int unsigned counts [5];
		int unsigned pick;
		bit          tx_steady;
		ledger = new();
		tx_steady = 1'b0;
		floors[0] = 32'h0010_0000;
		floors[1] = 32'hFFFF_FFFF;
		floors[2] = $urandom();
		floors[3] = 32'hFFFF_8000;
		floors[4] = 32'h0000_0000;
		counts[0] = 360;
		counts[1] = 80;
		counts[2] = 360;
		counts[3] = 240;
		counts[4] = 360;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty stack, extremes of freed frames, odd and even seals, skipped regions.
		send_request(REQ_ALLOC, '0, '0, 1'b0, '0);
		send_request(REQ_SEAL, '0, '0, 1'b0, '0);
		send_request(REQ_FREE, '0, '0, 1'b0, 32'hFFFF_FFFF);
		send_request(REQ_FREE, '0, '0, 1'b0, 32'h0000_0000);
		send_request(REQ_SEAL, '0, '0, 1'b0, '0);
		send_request(REQ_ALLOC, '0, '0, 1'b0, '0);
		send_request(REQ_ALLOC, '0, '0, 1'b0, '0);
		send_request(REQ_ADD, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0);
		send_request(REQ_ADD, 32'h0, 64'h0, 1'b1, '0);
		send_request(REQ_ADD, 32'h0000_1000, 64'h3001, 1'b1, '0);
		send_request(REQ_ADD, 32'h0000_2000, 64'h5000, 1'b1, '0);
		send_request(REQ_ADD, 32'hFFFF_F000, 64'hFFFF_FFFF_0000_2000, 1'b1, '0);
		send_request(REQ_SEAL, '0, '0, 1'b0, '0);
		send_request(REQ_ALLOC, '0, '0, 1'b0, '0);
		send_request(REQ_ALLOC, '0, '0, 1'b0, '0);
		send_request(REQ_FREE, '0, '0, 1'b0, 32'h1234_5678);
		send_request(REQ_SEAL, '0, '0, 1'b0, '0);
		send_request(REQ_ALLOC, '0, '0, 1'b0, '0);

		for (int p = 0; p < 5; p++) begin
			write_min_free(floors[p]);
			for (int unsigned i = 0; i < counts[p]; i++) begin
				random_request();
				if ($urandom_range(0, 59) == 0)
					tx_steady = !tx_steady;
				if ($urandom_range(0, 49) == 0) begin
					drain();
				end else if (!tx_steady) begin
					pick = $urandom_range(0, 99);
					if (pick >= 95)
						pause($urandom_range(8, 40));
					else if (pick >= 65)
						pause($urandom_range(1, 3));
				end
			end
		end

		// Directed: fill the stack from one huge region, then pushes, a seal and pops at full.
		write_min_free(32'h0);
		send_request(REQ_ADD, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '0);
		send_request(REQ_FREE, '0, '0, 1'b0, 32'hA5A5_5A5A);
		send_request(REQ_SEAL, '0, '0, 1'b0, '0);
		send_request(REQ_ALLOC, '0, '0, 1'b0, '0);
		send_request(REQ_FREE, '0, '0, 1'b0, 32'h0000_0FFF);
		send_request(REQ_FREE, '0, '0, 1'b0, 32'hFFFF_F000);
		send_request(REQ_ALLOC, '0, '0, 1'b0, '0);
		send_request(REQ_ALLOC, '0, '0, 1'b0, '0);

		drain();
		repeat (20) @(posedge clk);
		$display("Ran %0d requests across %0d floor settings; %0d frames loaded from regions, %0d seals.",
			sent, floor_writes, ledger.region_frames, ledger.seals);
		$display("Saw %0d allocations on an empty stack and %0d dropped pushes; %0d result beats compared.",
			ledger.empties, ledger.drops, ledger.matched);
		if (ledger.mismatches == 0 && ledger.owed_results.size() == 0)
			$display("page_frame_stack_allocator regression: pass");
		else
			$display("page_frame_stack_allocator regression: fail");
		$finish;
	end

endmodule
